/* rtl/tkc_pkg.sv */
`default_nettype none
package tkc_pkg;

  localparam int DELAY_LENGTH_DEF = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_DATA_W       = 17;
  localparam int CFG_INDEX_W      = 4;

  // register map
  localparam logic [CFG_INDEX_W-1:0] REG_KNEE_A_THR   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KNEE_A_INV   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KNEE_A_WIDTH = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KNEE_B_THR   = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KNEE_B_INV   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KNEE_B_WIDTH = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK       = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE      = 4'd7;

  localparam logic signed [19:0] LEVEL_FLOOR = -20'sd30720;
  localparam logic [18:0]        LOG_SCALE   = 19'd394566;  // 20*log10(2) in Q16
  localparam logic [21:0]        EXP_SCALE   = 22'd2786635; // log2(10)/20 in Q24
  localparam logic [16:0]        UNITY_Q16   = 17'd65536;
  localparam int                 GAIN_W      = 31;

  typedef struct packed {
    logic signed [15:0] thr;
    logic [16:0]        inv;
    logic [12:0]        wid;
  } knee_cfg_t;

  typedef struct packed {
    logic [15:0] attack;
    logic [15:0] rel;
  } smooth_cfg_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] reduction;
  } tkc_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // factors 2^(-2^-k), k = 1..16, in Q30; slot k-1 holds factor k
  function automatic logic [16*GAIN_W-1:0] gain_tab();
    logic [63:0]            c;
    logic [16*GAIN_W-1:0]   t;
    c = 64'd1 << 29;
    t = '0;
    for (int k = 0; k < 16; k++) begin
      c = isqrt64(c << 30);
      t[k*GAIN_W +: GAIN_W] = c[GAIN_W-1:0];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

/* rtl/two_knee_lookahead_compressor.sv */
`default_nettype none
// Two-knee soft-knee compressor with look-ahead, one signed 16-bit word in and
// one word out per sample. The front measures the level in dB (Q7.8) by
// sixteen squaring steps, runs it through knee A and knee B and hands the
// clamped static reduction, with the sample, to a two-word queue. The back
// smooths the reduction (attack/release one-pole), turns it into a linear gain
// over sixteen multiply steps and scales the sample leaving the DELAY_LENGTH
// deep delay line. Each knee that sits inside its knee region adds a square, a
// multiply and a divider to the front's work; a zero sample skips the squaring
// loop. The back's gain loop limits the sample rate when the knees stay outside
// their knee region and the front's knee divider when they sit inside it. The
// front takes a new sample once it has pushed the last one into the queue, while
// the back still works on earlier ones, and stalls while the queue is full. The
// delay line reads as all zeros after reset, through its valid bits, with no
// clearing pass. Write configuration only while no sample is in flight; indexes
// above seven are ignored, inverse ratios above 65536 read as 65536 and a knee
// width of zero reads as one.
module two_knee_lookahead_compressor
  import tkc_pkg::*;
#(
  parameter int DELAY_LENGTH = DELAY_LENGTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [15:0]     in_sample_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [15:0]          out_sample_out,
  output logic signed [15:0]          out_gain_reduction,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);
  knee_cfg_t   knee_a_r, knee_b_r;
  smooth_cfg_t smooth_r;

  tkc_word_t   push_word, pop_word;
  logic        push, pop;
  queue_stat_t q_stat;

  logic [16:0] inv_clamped;
  logic [12:0] wid_clamped;

  // clamp ratio to unity and width to at least one on the way in
  assign inv_clamped = (cfg_data > 17'd65536) ? 17'd65536 : cfg_data;
  assign wid_clamped = (cfg_data[12:0] == '0) ? 13'd1 : cfg_data[12:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knee_a_r <= '{thr: -16'sd1536, inv: 17'd32768, wid: 13'd512};
      knee_b_r <= '{thr: -16'sd384,  inv: 17'd3277,  wid: 13'd512};
      smooth_r <= '{attack: 16'd1351, rel: 16'd16};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KNEE_A_THR:   knee_a_r.thr    <= cfg_data[15:0];
        REG_KNEE_A_INV:   knee_a_r.inv    <= inv_clamped;
        REG_KNEE_A_WIDTH: knee_a_r.wid    <= wid_clamped;
        REG_KNEE_B_THR:   knee_b_r.thr    <= cfg_data[15:0];
        REG_KNEE_B_INV:   knee_b_r.inv    <= inv_clamped;
        REG_KNEE_B_WIDTH: knee_b_r.wid    <= wid_clamped;
        REG_ATTACK:       smooth_r.attack <= cfg_data[15:0];
        REG_RELEASE:      smooth_r.rel    <= cfg_data[15:0];
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  // level detection and static curve
  tkc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample_in),
    .knee_a    (knee_a_r),
    .knee_b    (knee_b_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_word (push_word)
  );

  // decouple the two halves so each stalls on its own
  tkc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .stat      (q_stat)
  );

  // smoothing, gain and look-ahead delay
  tkc_back #(.DELAY_LENGTH(DELAY_LENGTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_word        (pop_word),
    .q_stat        (q_stat),
    .pop           (pop),
    .smooth        (smooth_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample_out),
    .out_reduction (out_gain_reduction)
  );
endmodule
`default_nettype wire

/* rtl/tkc_queue.sv */
`default_nettype none
module tkc_queue
  import tkc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire tkc_word_t   push_word,
  input  wire logic        pop,
  output tkc_word_t        pop_word,
  output queue_stat_t      stat
);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tkc_word_t        entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign pop_word   = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end
endmodule
`default_nettype wire

/* rtl/tkc_front.sv */
`default_nettype none
module tkc_front
  import tkc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_sample,
  input  wire knee_cfg_t          knee_a,
  input  wire knee_cfg_t          knee_b,
  input  wire queue_stat_t        q_stat,
  output logic                    push,
  output tkc_word_t               push_word
);
  typedef enum logic [2:0] {
    F_IDLE, F_LOG, F_LVL, F_KSET, F_KSQ, F_KMUL, F_KDIV, F_PUSH
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic signed [15:0] x_r, x_nxt;
  logic [31:0]        m_r, m_nxt;
  logic [15:0]        frac_r, frac_nxt;
  logic [3:0]         e_r, e_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic signed [19:0] lvl_r, lvl_nxt;
  logic signed [19:0] kin_r, kin_nxt;
  logic               sel_r, sel_nxt;
  logic [13:0]        k2_r, k2_nxt;
  logic [27:0]        sq_r, sq_nxt;
  logic [26:0]        rem_r, rem_nxt;
  logic [13:0]        q_r, q_nxt;
  logic signed [15:0] gr_r, gr_nxt;

  knee_cfg_t          kc;
  logic [16:0]        ax;
  logic [45:0]        mshift;
  logic [63:0]        msq64;
  logic [33:0]        msq;
  logic [19:0]        mag;
  logic [38:0]        lprod;
  logic signed [19:0] thr20, o;
  logic signed [20:0] o2, ao2, w21;
  logic [33:0]        lin_prod;
  logic [34:0]        lin_sum;
  logic [45:0]        qnum;
  logic [26:0]        wsh;
  logic               knee_done;
  logic signed [19:0] kout, grf;

  assign in_ready  = (state_r == F_IDLE);
  assign push      = (state_r == F_PUSH) && !q_stat.full;
  assign push_word = '{sample: x_r, reduction: gr_r};

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r; m_nxt = m_r; frac_nxt = frac_r; e_nxt = e_r; cnt_nxt = cnt_r;
    lvl_nxt = lvl_r; kin_nxt = kin_r; sel_nxt = sel_r; k2_nxt = k2_r; sq_nxt = sq_r;
    rem_nxt = rem_r; q_nxt = q_r; gr_nxt = gr_r;
    knee_done = 1'b0;
    kout      = kin_r;

    ax     = in_sample[15] ? 17'(-{in_sample[15], in_sample}) : {1'b0, in_sample};
    mshift = '0;
    msq64  = m_r * m_r;
    msq    = msq64[63:30];
    mag    = {4'd15 - e_r, 16'd0} - {4'd0, frac_r};
    lprod  = mag * LOG_SCALE + 39'd8388608;

    kc       = sel_r ? knee_b : knee_a;
    thr20    = {{4{kc.thr[15]}}, kc.thr};
    w21      = {8'd0, kc.wid};
    o        = kin_r - thr20;
    o2       = {o, 1'b0};
    ao2      = o2[20] ? -o2 : o2;
    lin_prod = o[16:0] * kc.inv;
    lin_sum  = {1'b0, lin_prod} + 35'd32768;
    qnum     = (UNITY_Q16 - kc.inv) * sq_r + {15'd0, kc.wid, 18'd0};
    wsh      = 27'(kc.wid) << cnt_r;

    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          x_nxt   = in_sample;
          sel_nxt = 1'b0;
          if (ax == '0) begin
            lvl_nxt   = LEVEL_FLOOR;
            kin_nxt   = LEVEL_FLOOR;
            state_nxt = F_KSET;
          end else begin
            e_nxt = '0;
            for (int i = 0; i < 16; i++) begin
              if (ax[i]) e_nxt = 4'(i);
            end
            mshift    = {ax[15:0], 30'd0} >> e_nxt;
            m_nxt     = mshift[31:0];
            frac_nxt  = '0;
            cnt_nxt   = 4'd15;
            state_nxt = F_LOG;
          end
        end
      end
      F_LOG: begin
        // one squaring per fraction bit
        if (msq[31]) begin
          m_nxt    = msq[32:1];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          m_nxt    = msq[31:0];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = F_LVL;
      end
      F_LVL: begin
        lvl_nxt   = -$signed({5'd0, lprod[38:24]});
        kin_nxt   = -$signed({5'd0, lprod[38:24]});
        state_nxt = F_KSET;
      end
      F_KSET: begin
        if (o2 < -w21) begin
          knee_done = 1'b1;
          kout      = kin_r;
        end else if (ao2 <= w21) begin
          k2_nxt    = 14'(o2 + w21);
          state_nxt = F_KSQ;
        end else begin
          knee_done = 1'b1;
          kout      = thr20 + $signed({1'b0, lin_sum[34:16]});
        end
      end
      F_KSQ: begin
        sq_nxt    = k2_r * k2_r;
        state_nxt = F_KMUL;
      end
      F_KMUL: begin
        rem_nxt   = qnum[45:19];
        q_nxt     = '0;
        cnt_nxt   = 4'd13;
        state_nxt = F_KDIV;
      end
      F_KDIV: begin
        // restoring divide by the knee width, one quotient bit a cycle
        if (rem_r >= wsh) begin
          rem_nxt        = rem_r - wsh;
          q_nxt[cnt_r]   = 1'b1;
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          knee_done = 1'b1;
          kout      = kin_r - $signed({6'd0, q_nxt});
        end
      end
      F_PUSH: begin
        if (!q_stat.full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase

    grf = kout - lvl_r;
    if (knee_done) begin
      if (!sel_r) begin
        kin_nxt   = kout;
        sel_nxt   = 1'b1;
        state_nxt = F_KSET;
      end else begin
        if (grf > 0)             gr_nxt = '0;
        else if (grf < -20'sd32768) gr_nxt = -16'sd32768;
        else                     gr_nxt = grf[15:0];
        state_nxt = F_PUSH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      sel_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
    end
    x_r <= x_nxt; m_r <= m_nxt; frac_r <= frac_nxt; e_r <= e_nxt;
    lvl_r <= lvl_nxt; kin_r <= kin_nxt; k2_r <= k2_nxt; sq_r <= sq_nxt;
    rem_r <= rem_nxt; q_r <= q_nxt; gr_r <= gr_nxt;
  end
endmodule
`default_nettype wire

/* rtl/tkc_back.sv */
`default_nettype none
module tkc_back
  import tkc_pkg::*;
#(
  parameter int DELAY_LENGTH = DELAY_LENGTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tkc_word_t          q_word,
  input  wire queue_stat_t        q_stat,
  output logic                    pop,
  input  wire smooth_cfg_t        smooth,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_sample,
  output logic signed [15:0]      out_reduction
);
  localparam int PTR_W = (DELAY_LENGTH > 1) ? $clog2(DELAY_LENGTH) : 1;
  localparam logic [16*GAIN_W-1:0] GAIN_TAB = gain_tab();

  typedef enum logic [2:0] {
    B_IDLE, B_DIFF, B_STEP, B_EXP, B_GAIN, B_SCALE, B_ROUND
  } bstate_t;

  logic signed [15:0]      dly_mem [DELAY_LENGTH];
  logic [DELAY_LENGTH-1:0] dly_vld_r;
  logic [PTR_W-1:0]        pos_r;
  logic signed [15:0]      rd_r;
  logic                    rd_vld_r;

  bstate_t            state_r, state_nxt;
  logic signed [15:0] gr_r, gr_nxt;
  logic signed [31:0] s_r, s_nxt;
  logic [31:0]        absd_r, absd_nxt;
  logic               neg_r, neg_nxt;
  logic [15:0]        alpha_r, alpha_nxt;
  logic signed [15:0] del_r, del_nxt;
  logic [7:0]         ei_r, ei_nxt;
  logic [15:0]        ef_r, ef_nxt;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [47:0]        p_r, p_nxt;
  logic signed [15:0] grq_r, grq_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_sample_r, out_sample_nxt;
  logic signed [15:0] out_red_r, out_red_nxt;

  logic signed [31:0] g;
  logic signed [32:0] diff;
  logic [47:0]        sprod;
  logic [32:0]        nsum;
  logic [39:0]        eprod;
  logic [GAIN_W-1:0]  cfac;
  logic [61:0]        gprod;
  logic [GAIN_W-1:0]  gsh;
  logic [16:0]        adel;
  logic [47:0]        psum;
  logic [17:0]        pr;
  logic               slot_free;

  assign pop           = (state_r == B_IDLE) && !q_stat.empty;
  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_reduction = out_red_r;
  assign slot_free     = !out_valid_r || out_ready;

  // read old sample, write new one at the same slot
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_r           <= dly_mem[pos_r];
      dly_mem[pos_r] <= q_word.sample;
    end
  end

  always_comb begin
    state_nxt = state_r;
    gr_nxt = gr_r; s_nxt = s_r; absd_nxt = absd_r; neg_nxt = neg_r; alpha_nxt = alpha_r;
    del_nxt = del_r; ei_nxt = ei_r; ef_nxt = ef_r; gain_nxt = gain_r; cnt_nxt = cnt_r;
    p_nxt = p_r; grq_nxt = grq_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    out_red_nxt    = out_red_r;

    g     = {gr_r, 16'd0};
    diff  = {g[31], g} - {s_r[31], s_r};
    sprod = absd_r * alpha_r;
    nsum  = 33'd0 - {s_r[31], s_r} + 33'd32768;
    eprod = 40'(nsum[32:16] * EXP_SCALE) + 40'd32768;
    cfac  = GAIN_TAB[cnt_r*GAIN_W +: GAIN_W];
    gprod = gain_r * cfac + 62'd536870912;
    gsh   = (ei_r >= 8'd31) ? '0 : gain_r >> ei_r;
    adel  = del_r[15] ? 17'(-{del_r[15], del_r}) : {1'b0, del_r};
    psum  = p_r + 48'd536870912;
    pr    = psum[47:30];

    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          gr_nxt    = q_word.reduction;
          state_nxt = B_DIFF;
        end
      end
      B_DIFF: begin
        alpha_nxt = (g < s_r) ? smooth.attack : smooth.rel;
        neg_nxt   = diff[32];
        absd_nxt  = diff[32] ? 32'(-diff) : diff[31:0];
        del_nxt   = rd_vld_r ? rd_r : '0;
        state_nxt = B_STEP;
      end
      B_STEP: begin
        s_nxt     = neg_r ? s_r - $signed(sprod[47:16]) : s_r + $signed(sprod[47:16]);
        state_nxt = B_EXP;
      end
      B_EXP: begin
        grq_nxt   = 16'(-{1'b0, nsum[32:16]});
        ef_nxt    = eprod[31:16];
        ei_nxt    = eprod[39:32];
        gain_nxt  = GAIN_W'(1) << 30;
        cnt_nxt   = '0;
        state_nxt = B_GAIN;
      end
      B_GAIN: begin
        // fold in 2^(-2^-k) for each set fraction bit of the exponent
        if (ef_r[4'd15 - cnt_r]) gain_nxt = gprod[60:30];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'd15) state_nxt = B_SCALE;
      end
      B_SCALE: begin
        p_nxt     = 48'(adel * gsh);
        state_nxt = B_ROUND;
      end
      B_ROUND: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_red_nxt   = grq_r;
          if (!del_r[15]) out_sample_nxt = (pr > 18'd32767) ? 16'sd32767 : pr[15:0];
          else            out_sample_nxt = (pr > 18'd32768) ? -16'sd32768 : 16'(-pr);
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      s_r         <= '0;
      dly_vld_r   <= '0;
      pos_r       <= '0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_r         <= s_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        rd_vld_r         <= dly_vld_r[pos_r];
        dly_vld_r[pos_r] <= 1'b1;
        pos_r <= (pos_r == PTR_W'(DELAY_LENGTH - 1)) ? '0 : pos_r + 1'b1;
      end
    end
    gr_r <= gr_nxt; absd_r <= absd_nxt; neg_r <= neg_nxt; alpha_r <= alpha_nxt;
    del_r <= del_nxt; ei_r <= ei_nxt; ef_r <= ef_nxt; gain_r <= gain_nxt;
    p_r <= p_nxt; grq_r <= grq_nxt;
    out_sample_r <= out_sample_nxt; out_red_r <= out_red_nxt;
  end
endmodule
`default_nettype wire

/* rtl/tkc_checker.sv */
`default_nettype none
module tkc_checker
  import tkc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic signed [15:0]     in_sample_in,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic signed [15:0]     out_sample_out,
  input wire logic signed [15:0]     out_gain_reduction,
  input wire logic                   cfg_we,
  input wire logic [CFG_INDEX_W-1:0] cfg_index,
  input wire logic [CFG_DATA_W-1:0]  cfg_data
);
  // reduction never turns into gain
  a_gr_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gain_reduction[15] || out_gain_reduction == 16'sd0))
    else $error("positive gain reduction");

  // a held word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out)
                                && $stable(out_gain_reduction))
    else $error("output word changed while stalled");

  // reset empties the output
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // the front works on one sample at a time
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("front took a second sample while busy");
endmodule

bind two_knee_lookahead_compressor tkc_checker u_tkc_checker (.*);
`default_nettype wire
